// ===== src/assert_macros.svh =====
// assertion macros used by the top-level rtl file of the call signalling block
// no dependencies; NO_ASSERTIONS compiles every check away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CSH_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("check failed");
`define CSH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("check failed");
`define CSH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("check failed");
`else
`define CSH_ASSERT(lbl, clk, rstn, prop)
`define CSH_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CSH_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== src/csh_pkg.sv =====
// types, codes and constants of the call signalling handshake block
// used by every module of the block; no dependencies
package csh_pkg;

	localparam int TIMER_WIDTH_DEF = 16;
	localparam int PERIOD_W        = 16;

	localparam logic [15:0] INCOMING_PERIOD_RST = 16'd1000;
	localparam logic [15:0] NORMAL_PERIOD_RST   = 16'd2000;
	localparam logic [3:0]  RETRY_LIMIT_RST     = 4'd4;
	localparam logic [3:0]  EXPIRY_MAX          = 4'd15;

	// register indexes
	localparam logic [2:0] REG_PEER_ADDRESS    = 3'd0;
	localparam logic [2:0] REG_PEER_PORT       = 3'd1;
	localparam logic [2:0] REG_INCOMING_PERIOD = 3'd2;
	localparam logic [2:0] REG_NORMAL_PERIOD   = 3'd3;
	localparam logic [2:0] REG_RETRY_LIMIT     = 3'd4;

	// event codes
	localparam logic [2:0] OP_OPEN    = 3'd0;
	localparam logic [2:0] OP_CONTROL = 3'd1;
	localparam logic [2:0] OP_MEDIA   = 3'd2;
	localparam logic [2:0] OP_UNKNOWN = 3'd3;
	localparam logic [2:0] OP_TICK    = 3'd4;
	localparam logic [2:0] OP_ACCEPT  = 3'd5;
	localparam logic [2:0] OP_REJECT  = 3'd6;
	localparam logic [2:0] OP_SEND    = 3'd7;

	// message subtypes
	localparam logic [3:0] MSG_INVITE  = 4'd0;
	localparam logic [3:0] MSG_WAIT    = 4'd1;
	localparam logic [3:0] MSG_OK      = 4'd2;
	localparam logic [3:0] MSG_CANCEL  = 4'd3;
	localparam logic [3:0] MSG_ONLINE  = 4'd4;
	localparam logic [3:0] MSG_REPEAT  = 4'd5;
	localparam logic [3:0] MSG_UNKNOWN = 4'd6;
	localparam logic [3:0] MSG_AUDIO   = 4'd7;
	localparam logic [3:0] MSG_VIDEO   = 4'd8;

	// call phases, also the role codes of an open event (finish enters cancelled)
	localparam logic [2:0] PH_START     = 3'd0;
	localparam logic [2:0] PH_INCOMING  = 3'd1;
	localparam logic [2:0] PH_OUTGOING  = 3'd2;
	localparam logic [2:0] PH_TALK      = 3'd3;
	localparam logic [2:0] PH_CANCELLED = 3'd4;
	localparam logic [2:0] PH_ECHO      = 3'd5;

	typedef struct packed {
		logic [2:0]  operation;
		logic [2:0]  initial_role;
		logic [3:0]  subtype;
		logic [31:0] source_address;
		logic [15:0] source_port;
	} event_t;

	typedef struct packed {
		logic       send_valid;
		logic [3:0] send_kind;
		logic       send_to_source;
		logic       forward_media;
		logic       start_talk;
		logic       status_changed;
		logic       presence_valid;
		logic       presence_online;
		logic [2:0] call_state;
		logic       link_up;
	} result_t;

	typedef struct packed {
		logic [31:0]         peer_address;
		logic [15:0]         peer_port;
		logic [PERIOD_W-1:0] incoming_period;
		logic [PERIOD_W-1:0] normal_period;
		logic [3:0]          retry_limit;
	} cfg_t;

endpackage

// ===== src/call_signalling_handshake_fsm.sv =====
// call signalling handshake of one peer: top level with input and result registers
// depends on csh_pkg, csh_cfg_regs, csh_core and assert_macros.svh
//
// usage:
// - events enter on the s_ stream; one request per event, one result per event
//   on the m_ stream. s_tuser carries the event code and message subtype,
//   s_tdata the open role and the sender address and port
// - the cfg_ channel writes the peer address, peer port, the two timer periods
//   and the retry limit by register index; cfg_ready is always high. write it
//   only while no event is in flight
// - an accepted event passes through the input register, then the result
//   register; the state is updated on the edge that loads the result register
// - throughput: one event per cycle while m_tready is high; the call state,
//   timer and retry count are updated by one pass of next-state logic, so
//   consecutive events see each other's effect without gaps
// - when m_tready is low the result register holds, one more event waits in
//   the input register and s_tready drops until the result is taken
// - reset puts the call in the start phase with the timer stopped, retry
//   count and connected flag clear, and the registers at their defaults
`include "assert_macros.svh"

module call_signalling_handshake_fsm #(
	parameter int TIMER_WIDTH = csh_pkg::TIMER_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// initial_role[2:0], source_address[34:3], source_port[50:35], zero fill
	input  logic [55:0] s_tdata,
	// operation[2:0], subtype[6:3]
	input  logic [6:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// send_valid[0], send_to_source[1], forward_media[2], start_talk[3],
	// status_changed[4], presence_valid[5], presence_online[6], call_state[9:7],
	// link_up[10], zero fill
	output logic [15:0] m_tdata,
	// send_kind[3:0]
	output logic [3:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	csh_pkg::cfg_t    cfg;
	csh_pkg::event_t  ev_s1;
	logic             valid_s1;
	csh_pkg::result_t res_comb;
	csh_pkg::result_t res_s2;
	logic             valid_s2;
	logic             adv;
	logic             take;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || adv;
	assign take      = s_tvalid && s_tready;

	csh_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	csh_core #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.ev     (ev_s1),
		.cfg    (cfg),
		.res    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ev_s1.operation      <= s_tuser[2:0];
			ev_s1.subtype        <= s_tuser[6:3];
			ev_s1.initial_role   <= s_tdata[2:0];
			ev_s1.source_address <= s_tdata[34:3];
			ev_s1.source_port    <= s_tdata[50:35];
		end
		if (adv) begin
			res_s2 <= res_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.send_kind;
	assign m_tdata  = {5'b0, res_s2.link_up, res_s2.call_state, res_s2.presence_online,
	                   res_s2.presence_valid, res_s2.status_changed, res_s2.start_talk,
	                   res_s2.forward_media, res_s2.send_to_source, res_s2.send_valid};

	// a waiting event keeps its place until the result register frees
	`CSH_ASSERT_NXT(a_hold_s1, clk, arst_n, valid_s1 && !adv, valid_s1 && $stable(ev_s1))
	// every processed event lands in the result register
	`CSH_ASSERT_NXT(a_adv_result, clk, arst_n, adv, valid_s2)
	// a cancelled call is never shown as connected
	`CSH_ASSERT_IMP(a_cancel_down, clk, arst_n,
		valid_s2 && res_s2.call_state == csh_pkg::PH_CANCELLED, !res_s2.link_up)

endmodule

// ===== src/csh_cfg_regs.sv =====
// configuration register file of the call signalling block
// depends on csh_pkg
module csh_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [2:0]        wr_index,
	input  logic [31:0]       wr_data,
	output csh_pkg::cfg_t     cfg
);

	csh_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.peer_address    <= '0;
			cfg_q.peer_port       <= '0;
			cfg_q.incoming_period <= csh_pkg::INCOMING_PERIOD_RST;
			cfg_q.normal_period   <= csh_pkg::NORMAL_PERIOD_RST;
			cfg_q.retry_limit     <= csh_pkg::RETRY_LIMIT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				csh_pkg::REG_PEER_ADDRESS:    cfg_q.peer_address    <= wr_data;
				csh_pkg::REG_PEER_PORT:       cfg_q.peer_port       <= wr_data[15:0];
				csh_pkg::REG_INCOMING_PERIOD: cfg_q.incoming_period <= wr_data[15:0];
				csh_pkg::REG_NORMAL_PERIOD:   cfg_q.normal_period   <= wr_data[15:0];
				csh_pkg::REG_RETRY_LIMIT:     cfg_q.retry_limit     <= wr_data[3:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/csh_core.sv =====
// call state, retransmit timer and the next-state logic for one event
// depends on csh_pkg
module csh_core #(
	parameter int TIMER_WIDTH = csh_pkg::TIMER_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  csh_pkg::event_t   ev,
	input  csh_pkg::cfg_t     cfg,
	output csh_pkg::result_t  res
);

	localparam int CW = ((TIMER_WIDTH > csh_pkg::PERIOD_W) ? TIMER_WIDTH : csh_pkg::PERIOD_W) + 1;
	localparam logic [TIMER_WIDTH:0] CMAX = {1'b0, {TIMER_WIDTH{1'b1}}};

	logic [2:0]             phase_q;
	logic [TIMER_WIDTH-1:0] tick_q;
	logic                   run_q;
	logic [3:0]             exp_q;
	logic                   conn_q;

	logic [2:0]             ph_d;
	logic [TIMER_WIDTH-1:0] tick_d;
	logic                   run_d;
	logic [3:0]             exp_d;
	logic                   conn_d;

	logic [TIMER_WIDTH:0]   tick_inc;
	logic [CW-1:0]          inc_x;
	logic [CW-1:0]          per_x;
	logic                   expire;
	logic                   peer_match;
	logic                   timed_phase;
	logic [3:0]             exp_now;
	logic                   enter_en;
	logic [2:0]             enter_tgt;
	logic                   cancel_en;
	logic                   reenter_en;
	csh_pkg::result_t       r;

	assign tick_inc = {1'b0, tick_q} + {{TIMER_WIDTH{1'b0}}, 1'b1};
	assign inc_x    = CW'(tick_inc);
	assign per_x    = (phase_q == csh_pkg::PH_INCOMING) ? CW'(cfg.incoming_period)
	                                                    : CW'(cfg.normal_period);
	assign expire   = (inc_x >= per_x) || (tick_inc >= CMAX);

	assign peer_match  = (ev.source_address == cfg.peer_address) &&
	                     (ev.source_port == cfg.peer_port);
	assign timed_phase = (phase_q == csh_pkg::PH_OUTGOING) || (phase_q == csh_pkg::PH_TALK) ||
	                     (phase_q == csh_pkg::PH_ECHO);
	assign exp_now     = (timed_phase && (exp_q < csh_pkg::EXPIRY_MAX)) ? exp_q + 4'd1 : exp_q;

	always_comb begin
		ph_d       = phase_q;
		tick_d     = tick_q;
		run_d      = run_q;
		exp_d      = exp_q;
		conn_d     = conn_q;
		r          = '0;
		enter_en   = 1'b0;
		enter_tgt  = csh_pkg::PH_START;
		cancel_en  = 1'b0;
		reenter_en = 1'b0;

		unique case (ev.operation)
			csh_pkg::OP_OPEN: begin
				conn_d    = 1'b0;
				exp_d     = '0;
				tick_d    = '0;
				run_d     = 1'b0;
				ph_d      = csh_pkg::PH_START;
				enter_en  = 1'b1;
				enter_tgt = (ev.initial_role > csh_pkg::PH_ECHO) ? csh_pkg::PH_START
				                                                 : ev.initial_role;
			end
			csh_pkg::OP_CONTROL: begin
				if (peer_match) begin
					priority if (ev.subtype == csh_pkg::MSG_REPEAT) begin
						reenter_en = 1'b1;
					end else if (ev.subtype == csh_pkg::MSG_ONLINE &&
					             phase_q != csh_pkg::PH_ECHO) begin
						r.send_valid = 1'b1;
						r.send_kind  = csh_pkg::MSG_ONLINE;
					end else if (ev.subtype == csh_pkg::MSG_UNKNOWN) begin
						r.send_valid = 1'b1;
						r.send_kind  = csh_pkg::MSG_REPEAT;
					end else begin
						unique case (phase_q)
							csh_pkg::PH_INCOMING: begin
								if (ev.subtype == csh_pkg::MSG_INVITE) begin
									enter_en  = 1'b1;
									enter_tgt = csh_pkg::PH_INCOMING;
								end else if (ev.subtype == csh_pkg::MSG_CANCEL) begin
									enter_en  = 1'b1;
									enter_tgt = csh_pkg::PH_CANCELLED;
								end
							end
							csh_pkg::PH_OUTGOING: begin
								if (ev.subtype == csh_pkg::MSG_INVITE ||
								    ev.subtype == csh_pkg::MSG_OK) begin
									enter_en         = 1'b1;
									enter_tgt        = csh_pkg::PH_TALK;
									r.start_talk     = 1'b1;
									r.status_changed = 1'b1;
								end else if (ev.subtype == csh_pkg::MSG_CANCEL) begin
									enter_en  = 1'b1;
									enter_tgt = csh_pkg::PH_CANCELLED;
								end else if (ev.subtype == csh_pkg::MSG_WAIT) begin
									conn_d = 1'b1;
									exp_d  = '0;
									tick_d = '0;
									run_d  = 1'b1;
								end
							end
							csh_pkg::PH_TALK: begin
								if (ev.subtype == csh_pkg::MSG_CANCEL) begin
									enter_en  = 1'b1;
									enter_tgt = csh_pkg::PH_CANCELLED;
								end else if (ev.subtype == csh_pkg::MSG_OK) begin
									exp_d  = '0;
									conn_d = 1'b1;
								end else if (ev.subtype == csh_pkg::MSG_WAIT) begin
									enter_en  = 1'b1;
									enter_tgt = csh_pkg::PH_OUTGOING;
								end
							end
							csh_pkg::PH_ECHO: begin
								if (ev.subtype == csh_pkg::MSG_ONLINE) begin
									r.presence_valid  = 1'b1;
									r.presence_online = 1'b1;
									cancel_en         = 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
			end
			csh_pkg::OP_MEDIA: begin
				r.forward_media = (phase_q == csh_pkg::PH_TALK);
			end
			csh_pkg::OP_UNKNOWN: begin
				r.send_valid     = 1'b1;
				r.send_kind      = csh_pkg::MSG_REPEAT;
				r.send_to_source = 1'b1;
			end
			csh_pkg::OP_TICK: begin
				if (run_q) begin
					if (expire) begin
						tick_d = '0;
						exp_d  = exp_now;
						if (exp_now > cfg.retry_limit) begin
							if (phase_q == csh_pkg::PH_ECHO) begin
								r.presence_valid = 1'b1;
								cancel_en        = 1'b1;
							end else begin
								enter_en  = 1'b1;
								enter_tgt = csh_pkg::PH_CANCELLED;
							end
						end else begin
							reenter_en = 1'b1;
						end
					end else begin
						tick_d = tick_inc[TIMER_WIDTH-1:0];
					end
				end
			end
			csh_pkg::OP_ACCEPT: begin
				if (phase_q == csh_pkg::PH_INCOMING) begin
					enter_en         = 1'b1;
					enter_tgt        = csh_pkg::PH_TALK;
					r.start_talk     = 1'b1;
					r.status_changed = 1'b1;
				end
			end
			csh_pkg::OP_REJECT: begin
				enter_en  = 1'b1;
				enter_tgt = csh_pkg::PH_CANCELLED;
			end
			csh_pkg::OP_SEND: begin
				if (phase_q == csh_pkg::PH_TALK) begin
					r.send_valid = 1'b1;
					r.send_kind  = (ev.subtype == csh_pkg::MSG_VIDEO) ? csh_pkg::MSG_VIDEO
					                                                  : csh_pkg::MSG_AUDIO;
				end
			end
			default: begin
			end
		endcase

		// re-entry of the current phase; cancelled has nothing to resend
		if (reenter_en) begin
			if (phase_q == csh_pkg::PH_CANCELLED) begin
				cancel_en = 1'b1;
			end else begin
				enter_en  = 1'b1;
				enter_tgt = phase_q;
			end
		end

		if (enter_en) begin
			unique case (enter_tgt)
				csh_pkg::PH_START: begin
					ph_d = csh_pkg::PH_START;
				end
				csh_pkg::PH_INCOMING: begin
					ph_d         = csh_pkg::PH_INCOMING;
					r.send_valid = 1'b1;
					r.send_kind  = csh_pkg::MSG_WAIT;
					conn_d       = 1'b1;
					tick_d       = '0;
					run_d        = 1'b1;
				end
				csh_pkg::PH_OUTGOING: begin
					ph_d         = csh_pkg::PH_OUTGOING;
					r.send_valid = 1'b1;
					r.send_kind  = csh_pkg::MSG_INVITE;
					tick_d       = '0;
					run_d        = 1'b1;
				end
				csh_pkg::PH_TALK: begin
					ph_d         = csh_pkg::PH_TALK;
					r.send_valid = 1'b1;
					r.send_kind  = csh_pkg::MSG_OK;
					tick_d       = '0;
					run_d        = 1'b1;
				end
				csh_pkg::PH_CANCELLED: begin
					// finish: send cancel, then fall into the cancelled entry
					r.send_valid = 1'b1;
					r.send_kind  = csh_pkg::MSG_CANCEL;
					cancel_en    = 1'b1;
				end
				csh_pkg::PH_ECHO: begin
					ph_d         = csh_pkg::PH_ECHO;
					r.send_valid = 1'b1;
					r.send_kind  = csh_pkg::MSG_ONLINE;
					tick_d       = '0;
					run_d        = 1'b1;
				end
				default: begin
				end
			endcase
		end

		if (cancel_en) begin
			ph_d             = csh_pkg::PH_CANCELLED;
			run_d            = 1'b0;
			tick_d           = '0;
			exp_d            = '0;
			conn_d           = 1'b0;
			r.status_changed = 1'b1;
		end

		r.call_state = ph_d;
		r.link_up    = conn_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= csh_pkg::PH_START;
			tick_q  <= '0;
			run_q   <= 1'b0;
			exp_q   <= '0;
			conn_q  <= 1'b0;
		end else if (fire) begin
			phase_q <= ph_d;
			tick_q  <= tick_d;
			run_q   <= run_d;
			exp_q   <= exp_d;
			conn_q  <= conn_d;
		end
	end

	assign res = r;

endmodule
